/* rtl/touch_report_debouncer_defines.svh */
// ----------------------------------------------------------------------------
// Touch report debouncer assertion macros
// Shared property wrappers for the port checker on clk; most are quiet in rst.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_DEBOUNCER_DEFINES_SVH
`define TOUCH_REPORT_DEBOUNCER_DEFINES_SVH

// Same-cycle implication.
`define TDB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked also in the cycle that follows reset.
`define TDB_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/tdb_pkg.sv */
// ----------------------------------------------------------------------------
// Touch report debouncer package
// Shared types and fixed constants of the debouncer front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package tdb_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned READY_BIT = 7;            // status bit 7: data ready

  // Release after this many consecutive empty samples; accept 1..MAX_POINTS.
  localparam logic [COUNT_W-1:0] EMPTY_RUN_LIMIT = 4'd4;
  localparam logic [COUNT_W-1:0] MAX_POINTS      = 4'd5;

  localparam logic [COORD_W-1:0] WIDTH_LIMIT_RST  = 16'd800;
  localparam logic [COORD_W-1:0] HEIGHT_LIMIT_RST = 16'd480;

  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SWAP_AXES         = 3'd0,
    CFG_MIRROR_HORIZONTAL = 3'd1,
    CFG_MIRROR_VERTICAL   = 3'd2,
    CFG_WIDTH_LIMIT       = 3'd3,
    CFG_HEIGHT_LIMIT      = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic               swap_axes;
    logic               mirror_horizontal;
    logic               mirror_vertical;
    logic [COORD_W-1:0] width_limit;
    logic [COORD_W-1:0] height_limit;
  } cfg_t;

  // Classification of one sample as handed from front to back.
  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,   // failed read: no state change, no event
    KIND_TOUCH = 2'd1,   // valid touch: press or move
    KIND_EMPTY = 2'd2    // no valid point: counts towards release
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               clear_status;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] strength;
  } item_t;

endpackage

`default_nettype wire

/* rtl/tdb_front.sv */
// ----------------------------------------------------------------------------
// Touch report debouncer front
// Classifies each poll sample and applies swap, mirror and clamp to a touch.
// ----------------------------------------------------------------------------
`default_nettype none

module tdb_front
  import tdb_pkg::*;
(
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_failed,
  input  logic [STATUS_W-1:0] in_status,
  input  logic [COORD_W-1:0]  in_x,
  input  logic [COORD_W-1:0]  in_y,
  input  logic [COORD_W-1:0]  in_strength,
  output logic                push_valid,
  input  logic                push_ready,
  output item_t               push_item
);

  logic               ready_bit;
  logic [COUNT_W-1:0] status_points;
  logic               is_touch;
  logic [COORD_W-1:0] sw_x;
  logic [COORD_W-1:0] sw_y;
  logic [COORD_W-1:0] mir_x;
  logic [COORD_W-1:0] mir_y;
  logic [COORD_W-1:0] clp_x;
  logic [COORD_W-1:0] clp_y;

  assign ready_bit     = in_status[READY_BIT];
  assign status_points = in_status[COUNT_W-1:0];
  assign is_touch      = ready_bit && (status_points != '0) && (status_points <= MAX_POINTS);

  assign sw_x = cfg.swap_axes ? in_y : in_x;
  assign sw_y = cfg.swap_axes ? in_x : in_y;

  // Mirror inside the panel; anything at or beyond the limit folds to zero.
  assign mir_x = !cfg.mirror_horizontal ? sw_x :
                 (sw_x < cfg.width_limit) ? (cfg.width_limit - 16'd1 - sw_x) : '0;
  assign mir_y = !cfg.mirror_vertical ? sw_y :
                 (sw_y < cfg.height_limit) ? (cfg.height_limit - 16'd1 - sw_y) : '0;

  // Clamp below the limit; a zero limit wraps to all ones.
  assign clp_x = (mir_x >= cfg.width_limit)  ? (cfg.width_limit - 16'd1)  : mir_x;
  assign clp_y = (mir_y >= cfg.height_limit) ? (cfg.height_limit - 16'd1) : mir_y;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_item.x        = clp_x;
    push_item.y        = clp_y;
    push_item.strength = in_strength;
    if (in_failed) begin
      push_item.kind         = KIND_SKIP;
      push_item.clear_status = 1'b0;
    end else if (is_touch) begin
      push_item.kind         = KIND_TOUCH;
      push_item.clear_status = ready_bit;
    end else begin
      push_item.kind         = KIND_EMPTY;
      push_item.clear_status = ready_bit;
    end
  end

endmodule

`default_nettype wire

/* rtl/tdb_queue.sv */
// ----------------------------------------------------------------------------
// Touch report debouncer queue
// Short register queue between front and back; push and pop in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tdb_queue
  import tdb_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tdb_back.sv */
// ----------------------------------------------------------------------------
// Touch report debouncer back
// Holds press state and release counter, builds events into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdb_back
  import tdb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  item_t              pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_clear_status,
  output logic               out_report,
  output logic               out_pressed,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic [COORD_W-1:0] out_strength
);

  logic               held;
  logic [COUNT_W-1:0] empty_count;
  logic [COORD_W-1:0] kept_x;
  logic [COORD_W-1:0] kept_y;
  logic [COORD_W-1:0] kept_strength;

  logic               held_next;
  logic [COUNT_W-1:0] empty_count_next;
  logic [COUNT_W-1:0] count_step;
  logic               store;
  logic               rep_next;
  logic               prs_next;
  logic [COORD_W-1:0] x_next;
  logic [COORD_W-1:0] y_next;
  logic [COORD_W-1:0] s_next;
  logic               take;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;

  assign count_step = (empty_count < EMPTY_RUN_LIMIT) ? empty_count + 1'b1 : empty_count;

  always_comb begin
    held_next        = held;
    empty_count_next = empty_count;
    store            = 1'b0;
    rep_next         = 1'b0;
    prs_next         = 1'b0;
    x_next           = '0;
    y_next           = '0;
    s_next           = '0;
    unique case (pop_item.kind)
      KIND_TOUCH: begin
        store            = 1'b1;
        held_next        = 1'b1;
        empty_count_next = '0;
        rep_next         = 1'b1;
        prs_next         = 1'b1;
        x_next           = pop_item.x;
        y_next           = pop_item.y;
        s_next           = pop_item.strength;
      end
      KIND_EMPTY: begin
        if (held) begin
          empty_count_next = count_step;
          if (count_step >= EMPTY_RUN_LIMIT) begin
            held_next        = 1'b0;
            empty_count_next = '0;
            rep_next         = 1'b1;
            x_next           = kept_x;
            y_next           = kept_y;
            s_next           = kept_strength;
          end
        end else begin
          empty_count_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held          <= 1'b0;
      empty_count   <= '0;
      kept_x        <= '0;
      kept_y        <= '0;
      kept_strength <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        held        <= held_next;
        empty_count <= empty_count_next;
        if (store) begin
          kept_x        <= pop_item.x;
          kept_y        <= pop_item.y;
          kept_strength <= pop_item.strength;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_clear_status <= pop_item.clear_status;
      out_report       <= rep_next;
      out_pressed      <= prs_next;
      out_x            <= x_next;
      out_y            <= y_next;
      out_strength     <= s_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/touch_report_debouncer.sv */
// ----------------------------------------------------------------------------
// Touch report debouncer
// Turns touch controller poll samples into press, move and release events.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one poll sample per request. Output stream (m_*):
//   exactly one result per sample, in order, carrying the status-clear flag
//   and, when report is set, a press/move or release event with position.
//   Configuration (cfg_*): single-cycle writes of swap, mirror and the panel
//   limits; change it only while no sample is in flight.
//   Flow: an accepted sample is written into the queue, then taken by the back,
//   which updates its state and loads the output register behind m_tvalid.
//   Throughput: one sample per cycle while m_tready stays high.
//   Stall: when m_tready is low the output register holds its result and the
//   queue (QUEUE_DEPTH entries) keeps absorbing samples; s_tready drops only
//   once the queue is full.
//   Reset: rst clears the queue, the press state, the release counter and
//   the output valid, and returns the configuration to its defaults
//   (no swap, no mirror, 800 by 480).
// ----------------------------------------------------------------------------
`default_nettype none

module touch_report_debouncer
  import tdb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input sample stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [55:0]            s_tdata,    // status_byte, raw_x, raw_y, raw_strength
  input  logic [0:0]             s_tuser,    // read_failed
  // Result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [47:0]            m_tdata,    // pos_x, pos_y, strength
  output logic [2:0]             m_tuser,    // clear_status, report, pressed
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]     cfg_data
);

  cfg_t               cfg;
  logic               push_valid;
  logic               push_ready;
  item_t              push_item;
  logic               pop_valid;
  logic               pop_ready;
  item_t              pop_item;
  logic               res_clear;
  logic               res_report;
  logic               res_pressed;
  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_y;
  logic [COORD_W-1:0] res_s;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_axes         <= 1'b0;
      cfg.mirror_horizontal <= 1'b0;
      cfg.mirror_vertical   <= 1'b0;
      cfg.width_limit       <= WIDTH_LIMIT_RST;
      cfg.height_limit      <= HEIGHT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWAP_AXES:         cfg.swap_axes         <= cfg_data[0];
        CFG_MIRROR_HORIZONTAL: cfg.mirror_horizontal <= cfg_data[0];
        CFG_MIRROR_VERTICAL:   cfg.mirror_vertical   <= cfg_data[0];
        CFG_WIDTH_LIMIT:       cfg.width_limit       <= cfg_data;
        CFG_HEIGHT_LIMIT:      cfg.height_limit      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify and transform each accepted sample.
  tdb_front u_front (
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_failed   (s_tuser[0]),
    .in_status   (s_tdata[7:0]),
    .in_x        (s_tdata[23:8]),
    .in_y        (s_tdata[39:24]),
    .in_strength (s_tdata[55:40]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  // Queue: decouple front acceptance from back stalls.
  tdb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Back: debounce state and registered result.
  tdb_back u_back (
    .clk              (clk),
    .rst              (rst),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_clear_status (res_clear),
    .out_report       (res_report),
    .out_pressed      (res_pressed),
    .out_x            (res_x),
    .out_y            (res_y),
    .out_strength     (res_s)
  );

  assign m_tdata = {res_s, res_y, res_x};
  assign m_tuser = {res_pressed, res_report, res_clear};

endmodule

`default_nettype wire

/* rtl/tdb_checker.sv */
// ----------------------------------------------------------------------------
// Touch report debouncer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "touch_report_debouncer_defines.svh"

module tdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // A result with no event carries no event kind and no position.
  `TDB_ASSERT_NOW(a_no_event_zero, m_tvalid && !m_tuser[1], !m_tuser[2] && (m_tdata == 48'd0), "event fields set without report")

  // A press is only ever built from a ready sample, so it must clear status.
  `TDB_ASSERT_NOW(a_press_clears, m_tvalid && m_tuser[1] && m_tuser[2], m_tuser[0], "press reported without status clear")

  // Press kind never appears without the report flag.
  `TDB_ASSERT_NOW(a_pressed_needs_report, m_tvalid && m_tuser[2], m_tuser[1], "pressed set without report")

  // A stalled result holds.
  `TDB_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // Nothing is offered straight out of reset.
  `TDB_ASSERT_RST(a_quiet_after_reset, $past(rst), !m_tvalid, "result valid right after reset")

endmodule

bind touch_report_debouncer tdb_checker u_tdb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/touch_report_debouncer_test.sv */
// ----------------------------------------------------------------------------
// Touch report debouncer testbench
// Drives poll samples into the debouncer under several panel settings and
// checks every result against a cycle-free model of press, move and release
// debouncing, with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module touch_report_debouncer_test;
  import tdb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned PHASE_ITEMS  = 225;

  // One poll sample as offered on the input stream.
  typedef struct packed {
    logic               read_failed;
    logic [7:0]         status_byte;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [COORD_W-1:0] raw_strength;
  } poll_sample_t;

  // One result as seen on the output stream.
  typedef struct packed {
    logic               clear_status;
    logic               report;
    logic               pressed;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] strength;
  } touch_event_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [55:0]            s_tdata = '0;   // status_byte, raw_x, raw_y, raw_strength
  logic [0:0]             s_tuser = '0;   // read_failed
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [47:0]            m_tdata;        // pos_x, pos_y, strength
  logic [2:0]             m_tuser;        // clear_status, report, pressed
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]     cfg_data = '0;

  // Panel settings as the model sees them; change only while idle.
  logic               swap_xy = 1'b0;
  logic               flip_x  = 1'b0;
  logic               flip_y  = 1'b0;
  logic [COORD_W-1:0] panel_w = WIDTH_LIMIT_RST;
  logic [COORD_W-1:0] panel_h = HEIGHT_LIMIT_RST;

  // Debounce state of the model.
  logic               touch_down    = 1'b0;
  logic [COUNT_W-1:0] quiet_run     = '0;
  logic [COORD_W-1:0] last_x        = '0;
  logic [COORD_W-1:0] last_y        = '0;
  logic [COORD_W-1:0] last_strength = '0;

  poll_sample_t poll_q[$];          // samples waiting to be offered
  touch_event_t expected_events[$]; // results owed by the block, oldest first

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_armed    = 1'b0;
  logic        hold_taken    = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned samples_taken = 0;
  int unsigned press_count   = 0;
  int unsigned release_count = 0;
  int unsigned skip_count    = 0;
  int unsigned settings_run  = 1;
  int unsigned phase_pushed  = 0;

  touch_report_debouncer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Mirror against a limit; anything at or past the limit folds to zero.
  function automatic logic [COORD_W-1:0] mirror_coord(input logic [COORD_W-1:0] v,
                                                      input logic [COORD_W-1:0] lim);
    logic [COORD_W-1:0] folded;
    folded = lim - 16'd1 - v;
    return (v < lim) ? folded : '0;
  endfunction

  // Clamp to limit minus one; a zero limit wraps to all ones.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                     input logic [COORD_W-1:0] lim);
    logic [COORD_W-1:0] top;
    top = lim - 16'd1;
    return (v >= lim) ? top : v;
  endfunction

  // Work out the result of one accepted sample and advance the debounce state.
  function automatic touch_event_t debounce_sample(input poll_sample_t smp);
    touch_event_t       ev;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COUNT_W-1:0] points;
    logic               ready;
    ev     = '0;
    points = smp.status_byte[COUNT_W-1:0];
    ready  = smp.status_byte[READY_BIT];
    if (!smp.read_failed) begin
      ev.clear_status = ready;
      if (ready && points >= 4'd1 && points <= MAX_POINTS) begin
        x = swap_xy ? smp.raw_y : smp.raw_x;
        y = swap_xy ? smp.raw_x : smp.raw_y;
        if (flip_x) x = mirror_coord(x, panel_w);
        if (flip_y) y = mirror_coord(y, panel_h);
        x = clamp_coord(x, panel_w);
        y = clamp_coord(y, panel_h);
        last_x        = x;
        last_y        = y;
        last_strength = smp.raw_strength;
        touch_down    = 1'b1;
        quiet_run     = '0;
        ev.report     = 1'b1;
        ev.pressed    = 1'b1;
        ev.pos_x      = x;
        ev.pos_y      = y;
        ev.strength   = smp.raw_strength;
      end else if (touch_down) begin
        // Saturating count of empty samples; release once it reaches the mark.
        if (quiet_run < EMPTY_RUN_LIMIT) quiet_run = quiet_run + 4'd1;
        if (quiet_run >= EMPTY_RUN_LIMIT) begin
          touch_down  = 1'b0;
          quiet_run   = '0;
          ev.report   = 1'b1;
          ev.pos_x    = last_x;
          ev.pos_y    = last_y;
          ev.strength = last_strength;
        end
      end else begin
        quiet_run = '0;
      end
    end
    return ev;
  endfunction

  // Sender: advance to the next pending sample once the current request is taken.
  always @(posedge clk) begin : sender
    poll_sample_t smp;
    touch_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        smp = {s_tuser[0], s_tdata[7:0], s_tdata[23:8], s_tdata[39:24], s_tdata[55:40]};
        ev  = debounce_sample(smp);
        expected_events.push_back(ev);
        samples_taken++;
        if (smp.read_failed) skip_count++;
        if (ev.report && ev.pressed) press_count++;
        if (ev.report && !ev.pressed) release_count++;
      end
      // Hold a request that is still waiting; otherwise offer or idle.
      if (!s_tvalid || s_tready) begin
        if (poll_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          smp = poll_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {smp.raw_strength, smp.raw_y, smp.raw_x, smp.status_byte};
          s_tuser  <= smp.read_failed;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each taken result against the oldest expectation.
  always @(posedge clk) begin : receiver
    touch_event_t seen;
    touch_event_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = {m_tuser[0], m_tuser[1], m_tuser[2], m_tdata[15:0], m_tdata[31:16],
                m_tdata[47:32]};
        results_seen++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with nothing expected: ",
                     "clr=%0b rep=%0b prs=%0b x=%0d y=%0d s=%0d",
                     results_seen, seen.clear_status, seen.report, seen.pressed,
                     seen.pos_x, seen.pos_y, seen.strength);
        end else begin
          want = expected_events.pop_front();
          if (seen.clear_status !== want.clear_status || seen.report !== want.report ||
              seen.pressed !== want.pressed || seen.pos_x !== want.pos_x ||
              seen.pos_y !== want.pos_y || seen.strength !== want.strength) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("result %0d mismatch: expected ",
                       "clr=%0b rep=%0b prs=%0b x=%0d y=%0d s=%0d",
                       results_seen, want.clear_status, want.report, want.pressed,
                       want.pos_x, want.pos_y, want.strength);
              $display("result %0d mismatch: actual   ",
                       "clr=%0b rep=%0b prs=%0b x=%0d y=%0d s=%0d",
                       results_seen, seen.clear_status, seen.report, seen.pressed,
                       seen.pos_x, seen.pos_y, seen.strength);
            end
          end
        end
      end
      // Long hold-off once when armed, so the queue fills and input stalls.
      if (stall_left != 0) begin
        m_tready   <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (hold_armed && !hold_taken) begin
        m_tready   <= 1'b0;
        stall_left <= HOLD_CYCLES;
        hold_taken <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("touch_report_debouncer verification failed");
      $finish;
    end
  end

  task automatic push_sample(input logic failed, input logic [7:0] status,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] s);
    poll_q.push_back({failed, status, x, y, s});
    if (!failed) phase_pushed++;
  endtask

  // Wait until every request is taken and every result has come back.
  task automatic drain();
    while (poll_q.size() != 0 || s_tvalid || expected_events.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [COORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_SWAP_AXES:         swap_xy = value[0];
      CFG_MIRROR_HORIZONTAL: flip_x  = value[0];
      CFG_MIRROR_VERTICAL:   flip_y  = value[0];
      CFG_WIDTH_LIMIT:       panel_w = value;
      CFG_HEIGHT_LIMIT:      panel_h = value;
      default: ;
    endcase
  endtask

  // Small coordinates, full range, a band around the limit, or the extremes.
  function automatic logic [15:0] pick_coord(input logic [15:0] lim);
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'($urandom_range(0, 1023));
      1:       v = 16'($urandom);
      2:       v = lim + 16'($urandom_range(0, 4)) - 16'd2;
      default: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    return v;
  endfunction

  // One gesture: a run of touches, then a run of empty samples with skips.
  task automatic push_gesture();
    int unsigned touches;
    int unsigned quiet;
    logic [15:0] lim;
    touches = $urandom_range(1, 8);
    quiet   = $urandom_range(0, 6);
    for (int i = 0; i < touches; i++) begin
      lim = $urandom_range(0, 1) ? panel_w : panel_h;
      push_sample(1'b0, {1'b1, 3'($urandom), 4'($urandom_range(1, MAX_POINTS))},
                  pick_coord(lim), pick_coord(lim), 16'($urandom));
    end
    for (int i = 0; i < quiet; i++) begin
      case ($urandom_range(0, 5))
        0: push_sample(1'b1, 8'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom));
        1: push_sample(1'b0, {1'b1, 3'($urandom), 4'd0}, 16'($urandom),
                       16'($urandom), 16'($urandom));
        2: push_sample(1'b0, {1'b1, 3'($urandom), 4'($urandom_range(MAX_POINTS + 1, 15))},
                       16'($urandom), 16'($urandom), 16'($urandom));
        default: push_sample(1'b0, {1'b0, 7'($urandom)}, 16'($urandom), 16'($urandom),
                             16'($urandom));
      endcase
    end
  endtask

  task automatic run_phase(input logic sw, input logic mh, input logic mv,
                           input logic [15:0] w, input logic [15:0] h,
                           input int unsigned s_idle, input int unsigned r_idle);
    drain();
    write_reg(CFG_SWAP_AXES, {15'd0, sw});
    write_reg(CFG_MIRROR_HORIZONTAL, {15'd0, mh});
    write_reg(CFG_MIRROR_VERTICAL, {15'd0, mv});
    write_reg(CFG_WIDTH_LIMIT, w);
    write_reg(CFG_HEIGHT_LIMIT, h);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_run++;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    phase_pushed  = 0;
    while (phase_pushed < PHASE_ITEMS) begin
      // Mostly well-formed gestures; now and then a burst of pure noise.
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4))
          push_sample(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
      end else begin
        push_gesture();
      end
    end
  endtask

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 62;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings (800 by 480, no swap, no mirror).
    push_sample(1'b0, 8'h81, 16'h0000, 16'h0000, 16'h0000);  // touch at the origin
    push_sample(1'b0, 8'h85, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // top count, clamped
    push_sample(1'b0, 8'h8F, 16'd10, 16'd10, 16'd10);        // ready, count too high
    push_sample(1'b0, 8'h80, 16'd20, 16'd20, 16'd20);        // ready, no points
    push_sample(1'b1, 8'h81, 16'd30, 16'd30, 16'd30);        // failed read ignored
    push_sample(1'b0, 8'h05, 16'd40, 16'd40, 16'd40);        // points but not ready
    push_sample(1'b0, 8'h00, 16'd0, 16'd0, 16'd0);           // fourth empty: release
    push_sample(1'b0, 8'h86, 16'd1, 16'd2, 16'd3);           // empty while not held
    push_sample(1'b0, 8'h00, 16'd1, 16'd2, 16'd3);
    push_sample(1'b0, 8'hF3, 16'd799, 16'd479, 16'd1);       // just inside the limits
    push_sample(1'b0, 8'h82, 16'd800, 16'd480, 16'd2);       // on the limits: clamp
    push_sample(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // failed, all ones
    push_sample(1'b0, 8'hFF, 16'd0, 16'd0, 16'd0);
    push_sample(1'b0, 8'h7F, 16'd0, 16'd0, 16'd0);
    push_sample(1'b0, 8'h80, 16'd0, 16'd0, 16'd0);
    push_sample(1'b0, 8'h00, 16'd0, 16'd0, 16'd0);           // release after four
    push_sample(1'b0, 8'h84, 16'd123, 16'd456, 16'd789);
    push_sample(1'b0, 8'h80, 16'd0, 16'd0, 16'd0);
    push_sample(1'b0, 8'h81, 16'd321, 16'd123, 16'd55);      // touch resets the count
    repeat (4) push_sample(1'b0, 8'h00, 16'd0, 16'd0, 16'd0);
    push_sample(1'b0, 8'h00, 16'd0, 16'd0, 16'd0);           // empty after the release

    // Sender idles little, receiver much.
    run_phase(1'b1, 1'b1, 1'b1, 16'd800, 16'd480, 7, 62);
    run_phase(1'b0, 1'b1, 1'b0, 16'd1, 16'd65535, 7, 62);
    // Sender idles much, receiver little.
    run_phase(1'b1, 1'b0, 1'b1, 16'd65535, 16'd1, 62, 7);
    run_phase(1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 62, 7);        // zero limits wrap
    // No idling; arm the long output stall for the first of these.
    hold_armed = 1'b1;
    run_phase(1'b0, 1'b0, 1'b0, 16'($urandom_range(1, 65535)),
              16'($urandom_range(1, 65535)), 0, 0);
    run_phase(1'b0, 1'b1, 1'b1, 16'd320, 16'd240, 0, 0);
    run_phase(1'b1, 1'b0, 1'b0, 16'd65535, 16'd65535, 0, 0);
    drain();
    repeat (10) @(negedge clk);
    mismatches += expected_events.size();

    $display("covered %0d samples over %0d panel settings: ",
             "%0d presses or moves, %0d releases, %0d failed reads",
             samples_taken, settings_run, press_count, release_count, skip_count);
    $display("idling on each side in turn, one %0d-cycle output stall, %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("touch_report_debouncer verification clean");
    end else begin
      $display("touch_report_debouncer verification failed");
    end
    $finish;
  end

endmodule
